FILE: rtl/tea3_pkg.sv
// ----------------------------------------------------------------------------
// tea3_pkg
// Constants, tables and filter functions shared by the keystream generator.
// ----------------------------------------------------------------------------
package tea3_pkg;

    localparam int KEY_BYTES_DEF = 10;

    localparam logic [1:0] OP_RESTART  = 2'd0;
    localparam logic [1:0] OP_LOAD_IV  = 2'd1;
    localparam logic [1:0] OP_GENERATE = 2'd2;

    localparam logic [31:0] IV_MASK_WORD = 32'hC43A7D51;
    localparam logic [5:0]  FIRST_SKIP   = 6'd50;
    localparam logic [5:0]  NEXT_SKIP    = 6'd18;

    typedef struct packed {
        logic       start;
        logic       last;
    } t_step_ctl;

    localparam logic [7:0] SBOX [256] = '{
        8'h7D, 8'hBF, 8'h7B, 8'h92, 8'hAE, 8'h7C, 8'hF2, 8'h10,
        8'h5A, 8'h0F, 8'h61, 8'h7A, 8'h98, 8'h76, 8'h07, 8'h64,
        8'hEE, 8'h89, 8'hF7, 8'hBA, 8'hC2, 8'h02, 8'h0D, 8'hE8,
        8'h56, 8'h2E, 8'hCA, 8'h58, 8'hC0, 8'hFA, 8'h2A, 8'h01,
        8'h57, 8'h6E, 8'h3F, 8'h4B, 8'h9C, 8'hDA, 8'hA6, 8'h5B,
        8'h41, 8'h26, 8'h50, 8'h24, 8'h3E, 8'hF8, 8'h0A, 8'h86,
        8'hB6, 8'h5C, 8'h34, 8'hE9, 8'h06, 8'h88, 8'h1F, 8'h39,
        8'h33, 8'hDF, 8'hD9, 8'h78, 8'hD8, 8'hA8, 8'h51, 8'hB2,
        8'h09, 8'hCD, 8'hA1, 8'hDD, 8'h8E, 8'h62, 8'h69, 8'h4D,
        8'h23, 8'h2B, 8'hA9, 8'hE1, 8'h53, 8'h94, 8'h90, 8'h1E,
        8'hB4, 8'h3B, 8'hF9, 8'h4E, 8'h36, 8'hFE, 8'hB5, 8'hD1,
        8'hA2, 8'h8D, 8'h66, 8'hCE, 8'hB7, 8'hC4, 8'h60, 8'hED,
        8'h96, 8'h4F, 8'h31, 8'h79, 8'h35, 8'hEB, 8'h8F, 8'hBB,
        8'h54, 8'h14, 8'hCB, 8'hDE, 8'h6B, 8'h2D, 8'h19, 8'h82,
        8'h80, 8'hAC, 8'h17, 8'h05, 8'hFF, 8'hA4, 8'hCF, 8'hC6,
        8'h6F, 8'h65, 8'hE6, 8'h74, 8'hC8, 8'h93, 8'hF4, 8'h7E,
        8'hF3, 8'h43, 8'h9F, 8'h71, 8'hAB, 8'h9A, 8'h0B, 8'h87,
        8'h55, 8'h70, 8'h0C, 8'hAD, 8'hCC, 8'hA5, 8'h44, 8'hE7,
        8'h46, 8'h45, 8'h03, 8'h30, 8'h1A, 8'hEA, 8'h67, 8'h99,
        8'hDB, 8'h4A, 8'h42, 8'hD7, 8'hAA, 8'hE4, 8'hC2, 8'hD5,
        8'hF0, 8'h77, 8'h20, 8'hC3, 8'h3C, 8'h16, 8'hB9, 8'hE2,
        8'hEF, 8'h6C, 8'h3D, 8'h1B, 8'h22, 8'h84, 8'h2F, 8'h81,
        8'h1D, 8'hB1, 8'h3A, 8'hE5, 8'h73, 8'h40, 8'hD0, 8'h18,
        8'hC7, 8'h6A, 8'h9E, 8'h91, 8'h48, 8'h27, 8'h95, 8'h72,
        8'h68, 8'h0E, 8'h00, 8'hFC, 8'hC5, 8'h5F, 8'hF1, 8'hF5,
        8'h38, 8'h11, 8'h7F, 8'hE3, 8'h5E, 8'h13, 8'hAF, 8'h37,
        8'hE0, 8'h8A, 8'h49, 8'h1C, 8'h21, 8'h47, 8'hD4, 8'hDC,
        8'hB0, 8'hEC, 8'h83, 8'h28, 8'hB8, 8'hF6, 8'hA7, 8'hC9,
        8'h63, 8'h59, 8'hBD, 8'h32, 8'h85, 8'h08, 8'hBE, 8'hD3,
        8'hFD, 8'h4C, 8'h2C, 8'hFB, 8'hA0, 8'hC1, 8'h9D, 8'hB3,
        8'h52, 8'h8C, 8'h5D, 8'h29, 8'h6D, 8'h04, 8'hBC, 8'h25,
        8'h15, 8'h8B, 8'h12, 8'h9B, 8'hD6, 8'h75, 8'hA3, 8'h97
    };

    localparam logic [15:0] LOW_FILT [8] = '{
        16'h92A7, 16'hA761, 16'h974C, 16'h6B8C,
        16'h29CE, 16'h176C, 16'h39D4, 16'h7463
    };

    localparam logic [15:0] HIGH_FILT [8] = '{
        16'h9D58, 16'hA46D, 16'h176C, 16'h79C4,
        16'hC62B, 16'hB2C9, 16'h4D93, 16'h2E93
    };

    // output bit i looks at bits 5,6 of a and 5,6 of b rotated right by i
    function automatic logic [7:0] filt(input logic [15:0] pair, input logic high_sel);
        logic [7:0]  a;
        logic [7:0]  b;
        logic [3:0]  sel;
        logic [15:0] tab;
        logic [7:0]  res;
        a   = pair[7:0];
        b   = pair[15:8];
        res = 8'd0;
        for (int i = 0; i < 8; i++) begin
            sel    = {b[6], b[5], a[6], a[5]};
            tab    = high_sel ? HIGH_FILT[i] : LOW_FILT[i];
            res[i] = tab[sel];
            a      = {a[0], a[7:1]};
            b      = {b[0], b[7:1]};
        end
        return res;
    endfunction

    function automatic logic [7:0] shuffle(input logic [7:0] v);
        logic [7:0] r;
        r = 8'd0;
        r = r | ({v[1:0], 6'd0} & 8'h40);
        r = r | ({v[6:0], 1'b0} & 8'h20);
        r = r | ({v[5:0], 2'd0} & 8'h98);
        r = r | ({4'd0, v[7:4]} & 8'h04);
        r = r | ({3'd0, v[7:3]} & 8'h01);
        r = r | ({6'd0, v[7:6]} & 8'h02);
        return r;
    endfunction

endpackage

FILE: rtl/tea3_keystream_generator.sv
// ----------------------------------------------------------------------------
// tea3_keystream_generator
// TEA3 keystream generator with APB key registers and one shared step unit.
// ----------------------------------------------------------------------------
// Restart and load IV requests act on the step unit as they are accepted. A
// generate request runs one step of the key and state registers per cycle,
// with the step count set by FIRST_SKIP for the first byte after a restart and by NEXT_SKIP for each byte after that.
// The byte then waits in an output register; the next request is taken once
// it has gone.
module tea3_keystream_generator #(
    parameter int KEY_BYTES = tea3_pkg::KEY_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_iv,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_gamma_byte,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import tea3_pkg::*;

    localparam logic [3:0] ADDR_KEY_LOW  = 4'd0;
    localparam logic [3:0] ADDR_KEY_HIGH = 4'd8;

    logic [63:0] r_key_low;
    logic [15:0] r_key_high;
    logic        r_busy;
    logic [5:0]  r_count;
    logic [5:0]  r_skip;
    logic        r_out_valid;
    logic [7:0]  r_out;
    logic        accept;
    logic        wr;
    t_step_ctl   ctl;
    logic [79:0] key_all;
    logic [7:0]  top;

    assign pready  = 1'b1;
    assign wr      = psel && penable && pwrite;
    assign o_stall = r_busy || r_out_valid;
    assign accept  = i_valid && !o_stall;
    assign ctl.start = accept && (i_op == OP_GENERATE);
    assign ctl.last  = r_busy && (r_count == 6'd0);
    assign key_all = {r_key_high, r_key_low};
    assign o_valid = r_out_valid;
    assign o_gamma_byte = r_out;

    always_comb begin
        case (paddr)
            ADDR_KEY_LOW:  prdata = r_key_low;
            ADDR_KEY_HIGH: prdata = {48'd0, r_key_high};
            default:       prdata = 64'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= 64'd0;
            r_key_high <= 16'd0;
        end else if (wr) begin
            if (paddr == ADDR_KEY_LOW) r_key_low <= pwdata;
            if (paddr == ADDR_KEY_HIGH) r_key_high <= pwdata[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= 6'd0;
            r_skip      <= FIRST_SKIP;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) r_out_valid <= 1'b0;
            if (accept && i_op == OP_RESTART) r_skip <= FIRST_SKIP;
            if (ctl.start) begin
                r_busy  <= 1'b1;
                r_count <= r_skip;
            end else if (ctl.last) begin
                r_busy      <= 1'b0;
                r_skip      <= NEXT_SKIP;
                r_out_valid <= 1'b1;
            end else if (r_busy) begin
                r_count <= r_count - 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.last) r_out <= {top[7:0]};
    end

    tea3_step_unit #(.KEY_BYTES(KEY_BYTES)) u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load_key (accept && i_op == OP_RESTART),
        .i_key      (key_all[8*KEY_BYTES-1:0]),
        .i_load_iv  (accept && i_op == OP_LOAD_IV),
        .i_iv       (i_iv),
        .i_step     (r_busy),
        .o_next_top (top)
    );

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !accept) else $error("request taken while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> (r_out_valid && $stable(r_out)))
        else $error("result dropped under stall");
    a_skip_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skip == FIRST_SKIP) || (r_skip == NEXT_SKIP)) else $error("bad skip count");
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.last |=> (r_out_valid && !r_busy)) else $error("no result after run");
`endif

endmodule

FILE: rtl/tea3_step_unit.sv
// ----------------------------------------------------------------------------
// tea3_step_unit
// Key byte register and 64-bit state register, clocked one step per cycle while i_step is high.
// ----------------------------------------------------------------------------
module tea3_step_unit #(
    parameter int KEY_BYTES = tea3_pkg::KEY_BYTES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_load_key,
    input  logic [8*KEY_BYTES-1:0]   i_key,
    input  logic                     i_load_iv,
    input  logic [31:0]              i_iv,
    input  logic                     i_step,
    output logic [7:0]               o_next_top
);
    import tea3_pkg::*;

    logic [7:0]  r_kreg [KEY_BYTES];
    logic [63:0] r_state;
    logic [7:0]  sfb;
    logic [7:0]  ffb;
    logic [7:0]  mix;
    logic [7:0]  fb;
    logic [31:0] lo;
    logic [31:0] lo_rot;
    logic [63:0] iv_s;

    assign sfb    = SBOX[r_kreg[2] ^ r_kreg[7]] ^ r_kreg[0];
    assign ffb    = filt(r_state[23:8], 1'b0);
    assign mix    = filt(r_state[55:40], 1'b1);
    assign fb     = ffb ^ r_state[63:56] ^ shuffle(r_state[39:32]) ^ sfb;
    assign lo     = i_iv ^ IV_MASK_WORD;
    assign lo_rot = {lo[23:0], lo[31:24]};
    assign iv_s   = {i_iv, lo_rot};
    // top byte once the step in progress has been taken
    assign o_next_top = r_state[55:48];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < KEY_BYTES; k++) r_kreg[k] <= 8'd0;
            r_state <= 64'd0;
        end else if (i_load_key) begin
            for (int k = 0; k < KEY_BYTES; k++) r_kreg[k] <= i_key[8*k +: 8];
            r_state <= 64'd0;
        end else if (i_load_iv) begin
            r_state <= {iv_s[7:0], iv_s[63:8]};
        end else if (i_step) begin
            for (int k = 0; k < KEY_BYTES - 1; k++) r_kreg[k] <= r_kreg[k+1];
            r_kreg[KEY_BYTES-1] <= sfb;
            r_state <= {r_state[55:40], r_state[39:32] ^ mix, r_state[31:0], fb};
        end
    end

endmodule
